/* design/csem_pkg.sv */
// ---------------------------------------------------------------------------
// Counting semaphore table package
// Operation codes and field widths shared by the semaphore table design.
// ---------------------------------------------------------------------------
package csem_pkg;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_FREE   = 2'd1,
		OP_WAIT   = 2'd2,
		OP_SIGNAL = 2'd3
	} mode_t;

	localparam int INDEX_BITS = 4;
	localparam int DATA_BITS  = 16;

	localparam int S_TDATA_BITS = 24;
	localparam int S_TUSER_BITS = 2;
	localparam int M_TDATA_BITS = 24;
	localparam int M_TUSER_BITS = 1;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_NO_FREE = 1'b1;

endpackage

/* design/counting_semaphore_table.sv */
// A request moves from the input register to the result register, which drives m_tvalid.
// Throughput: one request per cycle while m_tready is high; the input register and the
// result register each hold one request; the flop table is read and updated between them.
// Reset: arst_n clears both pipeline valids and the whole table at once, so every entry
// is free with a zero count; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Counting semaphore table
// Flop-based table of counting semaphores with create, free, wait and signal.
// ---------------------------------------------------------------------------
module counting_semaphore_table #(
	parameter int NUM_SEMAPHORES = 16,
	parameter int COUNT_BITS     = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [3:0] sem_index, [19:4] initial_count, [23:20] zero
	input  logic [csem_pkg::S_TDATA_BITS-1:0]     s_tdata,
	// [1:0] mode
	input  logic [csem_pkg::S_TUSER_BITS-1:0]     s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [3:0] granted_index, [4] must_block, [5] wake_waiters, [21:6] count_after,
	// [23:22] zero
	output logic [csem_pkg::M_TDATA_BITS-1:0]     m_tdata,
	// [0] status
	output logic [csem_pkg::M_TUSER_BITS-1:0]     m_tuser
);

	localparam int IW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam logic signed [32:0] CMAX_W = (33'sd1 <<< (COUNT_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] CMIN_W = -CMAX_W - 33'sd1;
	localparam logic signed [COUNT_BITS-1:0] CMAX = CMAX_W[COUNT_BITS-1:0];
	localparam logic signed [COUNT_BITS-1:0] CMIN = CMIN_W[COUNT_BITS-1:0];
	localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic                                    v_s1;
	csem_pkg::mode_t                         mode_s1;
	logic [csem_pkg::INDEX_BITS-1:0]         idx_s1;
	logic signed [csem_pkg::DATA_BITS-1:0]   init_s1;

	logic                                    alloc_q [NUM_SEMAPHORES];
	logic signed [COUNT_BITS-1:0]            count_q [NUM_SEMAPHORES];

	logic                                    m_valid_q;
	logic                                    status_q;
	logic [csem_pkg::INDEX_BITS-1:0]         granted_q;
	logic                                    block_q;
	logic                                    wake_q;
	logic [csem_pkg::DATA_BITS-1:0]          after_q;

	logic                                    adv;
	logic                                    found;
	logic [IW-1:0]                           free_idx;
	logic [8:0]                              free_ext;
	logic [8:0]                              idx_ext;
	logic                                    in_range;
	logic [IW-1:0]                           sel;
	logic signed [COUNT_BITS-1:0]            cur;
	logic signed [32:0]                      init_w;
	logic signed [COUNT_BITS-1:0]            init_sat;
	logic                                    wr_en;
	logic [IW-1:0]                           wr_idx;
	logic                                    wr_alloc;
	logic signed [COUNT_BITS-1:0]            wr_count;
	logic                                    n_status;
	logic [csem_pkg::INDEX_BITS-1:0]         n_granted;
	logic                                    n_block;
	logic                                    n_wake;
	logic signed [COUNT_BITS-1:0]            n_after;
	logic signed [32:0]                      after_w;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= csem_pkg::mode_t'(s_tuser[1:0]);
			idx_s1  <= s_tdata[3:0];
			init_s1 <= s_tdata[19:4];
		end
	end

	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				found    = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign free_ext = {{(9 - IW){1'b0}}, free_idx};
	assign idx_ext  = {5'd0, idx_s1};
	assign in_range = idx_ext < 9'(NUM_SEMAPHORES);
	assign sel      = idx_ext[IW-1:0];
	assign cur      = in_range ? count_q[sel] : '0;

	assign init_w = 33'(init_s1);

	always_comb begin
		priority if (init_w > CMAX_W) begin
			init_sat = CMAX;
		end else if (init_w < CMIN_W) begin
			init_sat = CMIN;
		end else begin
			init_sat = init_w[COUNT_BITS-1:0];
		end
	end

	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = sel;
		wr_alloc  = in_range ? alloc_q[sel] : 1'b0;
		wr_count  = cur;
		n_status  = csem_pkg::STATUS_DONE;
		n_granted = '0;
		n_block   = 1'b0;
		n_wake    = 1'b0;
		n_after   = '0;
		unique case (mode_s1)
			csem_pkg::OP_CREATE: begin
				if (found) begin
					wr_en     = 1'b1;
					wr_idx    = free_idx;
					wr_alloc  = 1'b1;
					wr_count  = init_sat;
					n_granted = free_ext[3:0];
					n_after   = init_sat;
				end else begin
					n_status = csem_pkg::STATUS_NO_FREE;
				end
			end
			csem_pkg::OP_FREE: begin
				if (in_range) begin
					wr_en   = 1'b1;
					n_after = cur;
					if (cur > 0) begin
						wr_alloc = 1'b0;
					end
				end
			end
			csem_pkg::OP_WAIT: begin
				if (in_range) begin
					wr_en    = 1'b1;
					wr_count = (cur != CMIN) ? cur - CNT_ONE : cur;
					n_block  = wr_count < 0;
					n_after  = wr_count;
				end
			end
			csem_pkg::OP_SIGNAL: begin
				if (in_range) begin
					wr_en    = 1'b1;
					wr_count = (cur != CMAX) ? cur + CNT_ONE : cur;
					n_wake   = wr_count <= 0;
					n_after  = wr_count;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign after_w = 33'(n_after);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMAPHORES; i++) begin
				alloc_q[i] <= 1'b0;
				count_q[i] <= '0;
			end
		end else if (v_s1 && adv && wr_en) begin
			alloc_q[wr_idx] <= wr_alloc;
			count_q[wr_idx] <= wr_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			status_q  <= n_status;
			granted_q <= n_granted;
			block_q   <= n_block;
			wake_q    <= n_wake;
			after_q   <= after_w[csem_pkg::DATA_BITS-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, after_q, wake_q, block_q, granted_q};
	assign m_tuser  = status_q;

`ifndef ASSERT_OFF
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && status_q |-> granted_q == '0 && after_q == '0 && !block_q && !wake_q)
		else $error("failed create carries nonzero result fields");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(block_q && wake_q))
		else $error("must_block and wake_waiters both set");

	a_create_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv && mode_s1 == csem_pkg::OP_CREATE && found |=> alloc_q[$past(free_idx)])
		else $error("created entry not marked allocated");

	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv && mode_s1 == csem_pkg::OP_CREATE && !found |=> status_q)
		else $error("full table did not report failure");
`endif

endmodule

/* dv/tb_counting_semaphore_table.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Counting semaphore table testbench
// Drives create, free, wait and signal requests with random idling on both
// stream sides and compares each result with a semaphore table kept here.
// ---------------------------------------------------------------------------
module tb_counting_semaphore_table;

	localparam int NUM_SEM = 16;
	localparam int IDX_W = csem_pkg::INDEX_BITS;
	localparam int CNT_W = csem_pkg::DATA_BITS;
	localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sh7fff;
	localparam logic signed [CNT_W-1:0] COUNT_MIN = 16'sh8000;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int DEEP_NEG_LIMIT = 4;

	typedef struct packed {
		logic                          status;
		logic [IDX_W-1:0]              granted;
		logic                          blk;
		logic                          wake;
		logic signed [CNT_W-1:0]       count_after;
	} sem_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [csem_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
	logic [csem_pkg::S_TUSER_BITS-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [csem_pkg::M_TDATA_BITS-1:0] m_tdata;
	logic [csem_pkg::M_TUSER_BITS-1:0] m_tuser;

	sem_result_t expected_results[$];
	logic sem_alloc [NUM_SEM];
	logic signed [CNT_W-1:0] sem_count [NUM_SEM];
	int error_count = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	int hold_off_cycles = 0;

	always #5 clk = ~clk;

	counting_semaphore_table #(
		.NUM_SEMAPHORES(NUM_SEM),
		.COUNT_BITS(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	function automatic sem_result_t apply_op(input csem_pkg::mode_t op,
			input logic [IDX_W-1:0] idx, input logic signed [CNT_W-1:0] init);
		sem_result_t r;
		logic signed [CNT_W-1:0] c;
		r = '0;
		r.status = csem_pkg::STATUS_DONE;
		c = sem_count[idx];
		case (op)
			csem_pkg::OP_CREATE: begin
				r.status = csem_pkg::STATUS_NO_FREE;
				for (int i = 0; i < NUM_SEM; i++) begin
					if (!sem_alloc[i] && r.status == csem_pkg::STATUS_NO_FREE) begin
						sem_alloc[i] = 1'b1;
						sem_count[i] = init;
						r.count_after = init;
						r.granted = i[IDX_W-1:0];
						r.status = csem_pkg::STATUS_DONE;
					end
				end
			end
			csem_pkg::OP_FREE: begin
				if (sem_alloc[idx] && c > 0)
					sem_alloc[idx] = 1'b0;
				r.count_after = c;
			end
			csem_pkg::OP_WAIT: begin
				if (c != COUNT_MIN)
					c = c - 16'sd1;
				r.blk = (c < 0);
				sem_count[idx] = c;
				r.count_after = c;
			end
			csem_pkg::OP_SIGNAL: begin
				if (c != COUNT_MAX)
					c = c + 16'sd1;
				r.wake = (c <= 0);
				sem_count[idx] = c;
				r.count_after = c;
			end
		endcase
		return r;
	endfunction

	task automatic send_request(input csem_pkg::mode_t op, input logic [IDX_W-1:0] idx,
			input logic signed [CNT_W-1:0] init);
		int gap;
		gap = sender_idles ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = {4'b0000, init, idx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(apply_op(op, idx, init));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic int deep_negative_entries();
		int n;
		n = 0;
		for (int i = 0; i < NUM_SEM; i++)
			if (sem_alloc[i] && sem_count[i] < -8)
				n++;
		return n;
	endfunction

	function automatic logic [IDX_W-1:0] pick_allocated(input bit want_positive);
		logic [IDX_W-1:0] candidates[$];
		for (int i = 0; i < NUM_SEM; i++)
			if (sem_alloc[i] && (!want_positive || sem_count[i] > 0))
				candidates.push_back(i[IDX_W-1:0]);
		if (candidates.size() == 0)
			return IDX_W'($urandom_range(0, NUM_SEM - 1));
		return candidates[$urandom_range(0, candidates.size() - 1)];
	endfunction

	// Counts that sink far below zero cannot be freed until signals lift them above zero, so
	// they are rationed to keep the table turning over.
	function automatic logic signed [CNT_W-1:0] random_initial_count();
		int r;
		logic [31:0] v;
		bit neg_ok;
		r = $urandom_range(0, 99);
		neg_ok = deep_negative_entries() < DEEP_NEG_LIMIT;
		if (r < 70) begin
			return CNT_W'($signed($urandom_range(0, 8)) - 4);
		end else if (r < 85) begin
			v = $urandom;
			if (v[15] && !neg_ok)
				v[15] = 1'b0;
			return v[15:0];
		end else begin
			case ($urandom_range(0, 5))
				0: return COUNT_MAX;
				1: return COUNT_MAX - 16'sd1;
				2: return neg_ok ? COUNT_MIN : 16'sd1;
				3: return neg_ok ? COUNT_MIN + 16'sd1 : 16'sd2;
				4: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
	endfunction

	task automatic send_random_request();
		int r;
		csem_pkg::mode_t op;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(0, 99);
		op = (r < 25) ? csem_pkg::OP_CREATE : (r < 45) ? csem_pkg::OP_FREE :
			(r < 72) ? csem_pkg::OP_WAIT : csem_pkg::OP_SIGNAL;
		idx = IDX_W'($urandom_range(0, NUM_SEM - 1));
		if (op != csem_pkg::OP_CREATE && $urandom_range(0, 9) < 8)
			idx = pick_allocated(op == csem_pkg::OP_FREE);
		send_request(op, idx, random_initial_count());
	endtask

	task automatic test_create_until_full();
		send_request(csem_pkg::OP_CREATE, 4'hf, COUNT_MAX);
		send_request(csem_pkg::OP_CREATE, 4'h0, COUNT_MIN);
		send_request(csem_pkg::OP_CREATE, 4'h5, 16'sd1);
		send_request(csem_pkg::OP_CREATE, 4'ha, 16'sd0);
		send_request(csem_pkg::OP_CREATE, 4'h3, -16'sd1);
		for (int i = 5; i < NUM_SEM; i++)
			send_request(csem_pkg::OP_CREATE, IDX_W'($urandom_range(0, 15)),
				CNT_W'(i - 10));
		send_request(csem_pkg::OP_CREATE, 4'h7, 16'sd5);
	endtask

	task automatic test_count_limits();
		send_request(csem_pkg::OP_SIGNAL, 4'd0, 16'sd0);
		send_request(csem_pkg::OP_WAIT, 4'd1, 16'sd0);
		send_request(csem_pkg::OP_SIGNAL, 4'd4, 16'sd0);
	endtask

	task automatic test_free_rules();
		send_request(csem_pkg::OP_FREE, 4'd1, 16'sd0);
		send_request(csem_pkg::OP_FREE, 4'd4, 16'sd0);
		send_request(csem_pkg::OP_FREE, 4'd2, 16'sd0);
	endtask

	task automatic test_unallocated_entry();
		send_request(csem_pkg::OP_WAIT, 4'd2, 16'sd0);
		send_request(csem_pkg::OP_WAIT, 4'd2, 16'sd0);
		send_request(csem_pkg::OP_SIGNAL, 4'd2, 16'sd0);
		send_request(csem_pkg::OP_FREE, 4'd2, 16'sd0);
		send_request(csem_pkg::OP_CREATE, 4'd9, 16'sd100);
		wait_drained();
	endtask

	// The result side stops for a long stretch while requests keep coming, so the
	// block fills up and must hold s_tready low.
	task automatic test_receiver_hold_off();
		hold_off_cycles = LONG_HOLD_CYCLES;
		sender_idles = 1'b0;
		repeat (60) send_random_request();
		sender_idles = 1'b1;
		wait_drained();
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < 1400; n++) begin
			if (n % 100 == 0) begin
				sender_idles = 1'($urandom_range(0, 1));
				receiver_idles = 1'($urandom_range(0, 1));
			end
			send_random_request();
		end
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	task automatic test_sender_pause();
		repeat (5) begin
			repeat (20) send_random_request();
			wait_drained();
		end
	endtask

	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				m_tready = 1'b0;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
			end
			gap = receiver_idles ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin : result_check
		sem_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[0] !== want.status)
					report_mismatch($sformatf("status %b, expected %b", m_tuser[0], want.status));
				if (m_tdata[3:0] !== want.granted)
					report_mismatch($sformatf("granted_index %0d, expected %0d",
						m_tdata[3:0], want.granted));
				if (m_tdata[4] !== want.blk)
					report_mismatch($sformatf("must_block %b, expected %b", m_tdata[4], want.blk));
				if (m_tdata[5] !== want.wake)
					report_mismatch($sformatf("wake_waiters %b, expected %b",
						m_tdata[5], want.wake));
				if (m_tdata[21:6] !== want.count_after)
					report_mismatch($sformatf("count_after %0d, expected %0d",
						$signed(m_tdata[21:6]), want.count_after));
				if (m_tdata[23:22] !== 2'b00)
					report_mismatch($sformatf("tdata padding %b, expected 00", m_tdata[23:22]));
			end
		end
	end

	initial begin : run_tests
		for (int i = 0; i < NUM_SEM; i++) begin
			sem_alloc[i] = 1'b0;
			sem_count[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_create_until_full();
		test_count_limits();
		test_free_rules();
		test_unallocated_entry();
		test_receiver_hold_off();
		test_random_traffic();
		test_sender_pause();
		wait_drained();
		repeat (5) @(posedge clk);
		if (error_count == 0)
			$display("tb_counting_semaphore_table: clean");
		else
			$display("tb_counting_semaphore_table: errors");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("tb_counting_semaphore_table: errors");
		$finish;
	end

endmodule
